// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the integrator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define OFVI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// condition must never be seen outside reset
`define OFVI_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition");

`endif

// ===== hdl/ofvi_pkg.sv =====
// ----------------------------------------------------------------------------
// ofvi_pkg
// types, constants and helpers of the flow velocity integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ofvi_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_FOCAL      = 3'd0,
    CFG_NEW_WEIGHT     = 3'd1,
    CFG_THROTTLE       = 3'd2,
    CFG_USE_LOWPASS    = 3'd3,
    CFG_USE_FILT_RANGE = 3'd4
  } cfg_idx_t;

  localparam logic [23:0] RST_INV_FOCAL   = 24'd25166;
  localparam logic [16:0] RST_NEW_WEIGHT  = 17'd6554;
  localparam logic [7:0]  RST_THROTTLE    = 8'd10;
  localparam logic        RST_USE_LOWPASS = 1'b0;
  localparam logic        RST_USE_FILT    = 1'b1;

  // 10^6 / 2^6, shared by velocity and gyro scaling
  localparam logic [15:0] SCALE_15625 = 16'd15625;
  localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
  localparam int          DIV_NUM_W   = 48;
  localparam int          DIV_DEN_W   = 16;
  localparam int          DIV_STEPS   = DIV_NUM_W / 2;

  typedef struct packed {
    logic signed [15:0] flow_x_px;
    logic signed [15:0] flow_y_px;
    logic [7:0]         flow_quality;
    logic               range_valid;
    logic [15:0]        range_filtered_mm;
    logic [15:0]        range_raw_mm;
    logic signed [15:0] sensor_rate_x;
    logic signed [15:0] sensor_rate_y;
    logic signed [15:0] sensor_rate_z;
    logic [15:0]        frame_interval_us;
    logic [19:0]        since_last_us;
    logic [31:0]        range_age_us;
  } ofvi_in_t;

  typedef struct packed {
    logic               report_valid;
    logic [15:0]        ground_distance_mm;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic [31:0]        window_time_us;
    logic signed [31:0] window_flow_x;
    logic signed [31:0] window_flow_y;
    logic signed [31:0] window_gyro_x;
    logic signed [31:0] window_gyro_y;
    logic signed [31:0] window_gyro_z;
    logic [7:0]         mean_quality;
    logic [31:0]        range_age_out_us;
  } ofvi_out_t;

  typedef struct packed {
    logic [23:0] inv_focal_length;
    logic [16:0] new_weight;
    logic [7:0]  throttle_factor;
    logic        use_lowpass;
    logic        use_filtered_range;
  } ofvi_cfg_t;

  // classified frame as it travels from front to back
  typedef struct packed {
    logic             flow_ok;
    logic             range_valid;
    logic [1:0][15:0] flow_mag;
    logic [1:0]       flow_neg;
    logic [1:0]       flow_pos;
    logic [2:0][15:0] rate_mag;
    logic [2:0]       rate_neg;
    logic [15:0]      range_f;
    logic [15:0]      ground;
    logic [15:0]      interval;
    logic [19:0]      dt;
    logic [31:0]      age;
    logic [7:0]       qual;
  } ofvi_work_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } ofvi_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } ofvi_div_rsp_t;

  function automatic logic [15:0] abs16(input logic [15:0] x);
    return x[15] ? 16'(~x + 16'd1) : x;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? 32'(~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && v[32:31] != 2'b00) r = 32'h7FFF_FFFF;
    else if (v[33] && v[32:31] != 2'b11) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic [19:0] v);
    logic [15:0] r;
    if (!v[19] && v[18:15] != 4'b0000) r = 16'h7FFF;
    else if (v[19] && v[18:15] != 4'b1111) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  // magnitude with sign to saturated 16-bit value
  function automatic logic [15:0] mag_to_s16(input logic [DIV_NUM_W-1:0] mag,
                                             input logic big, input logic neg);
    logic [15:0] r;
    if (neg) begin
      r = (big || mag > 48'd32768) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
    end else begin
      r = (big || mag > 48'd32767) ? 16'h7FFF : mag[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/optical_flow_velocity_integrator.sv =====
// a frame without usable flow skips the velocity and gyro divisions; a window report
//   adds its mean divisions
// throughput: one frame at a time, bounded by the shared 2-bit-per-cycle divider (up to 8
//   divisions per frame)
// reset: synchronous active-low rst_n restores register defaults and clears all sums
// ----------------------------------------------------------------------------
// optical_flow_velocity_integrator
// metric velocity, low-pass and windowed angular integration from frame flow
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module optical_flow_velocity_integrator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // frame beats in
  input  wire                                 in_push,
  output logic                                in_full,
  input  ofvi_pkg::ofvi_in_t                  in_data,
  // report beats out
  output logic                                out_empty,
  input  wire                                 out_pop,
  output ofvi_pkg::ofvi_out_t                 out_data,
  // register writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [ofvi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [ofvi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ofvi_pkg::*;

  ofvi_cfg_t  cfg_r;
  ofvi_work_t front_work;
  ofvi_work_t q_data;
  logic       q_push;
  logic       q_pop;
  logic       q_empty;

  // register writes are always accepted; the user must issue them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_focal_length   <= RST_INV_FOCAL;
      cfg_r.new_weight         <= RST_NEW_WEIGHT;
      cfg_r.throttle_factor    <= RST_THROTTLE;
      cfg_r.use_lowpass        <= RST_USE_LOWPASS;
      cfg_r.use_filtered_range <= RST_USE_FILT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INV_FOCAL:      cfg_r.inv_focal_length   <= cfg_data;
        CFG_NEW_WEIGHT:     cfg_r.new_weight         <= cfg_data[16:0];
        CFG_THROTTLE:       cfg_r.throttle_factor    <= cfg_data[7:0];
        CFG_USE_LOWPASS:    cfg_r.use_lowpass        <= cfg_data[0];
        CFG_USE_FILT_RANGE: cfg_r.use_filtered_range <= cfg_data[0];
        default:            ; // unused index, write dropped
      endcase
    end
  end

  // front: range gating, axis remap, sign/magnitude split
  ofvi_front u_front (
    .in_data(in_data),
    .cfg    (cfg_r),
    .in_push(in_push),
    .q_full (in_full),
    .q_push (q_push),
    .work   (front_work)
  );

  // decoupling queue so new frames land while the back end is busy
  ofvi_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(front_work),
    .full (in_full),
    .pop  (q_pop),
    .rdata(q_data),
    .empty(q_empty)
  );

  // back: multiply/divide sequencer, window state and the output register
  ofvi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/ofvi_div.sv =====
// ----------------------------------------------------------------------------
// ofvi_div
// shared unsigned radix-4 restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofvi_div (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ofvi_pkg::ofvi_div_req_t req,
  output ofvi_pkg::ofvi_div_rsp_t rsp
);
  import ofvi_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] sh_r;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic [DIV_NUM_W-1:0] sh_nxt;

  always_comb begin
    logic [DIV_DEN_W:0] t;
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    for (int i = 0; i < 2; i++) begin
      t      = {rem_nxt, sh_nxt[DIV_NUM_W-1]};
      sh_nxt = {sh_nxt[DIV_NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t         = t - {1'b0, den_r};
        sh_nxt[0] = 1'b1;
      end
      rem_nxt = t[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= req.den;
        sh_r   <= req.num;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= sh_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = sh_r;

endmodule

`default_nettype wire

// ===== hdl/ofvi_front.sv =====
// ----------------------------------------------------------------------------
// ofvi_front
// accepts frame beats, gates ranges, remaps gyro axes and splits signs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofvi_front (
  input  ofvi_pkg::ofvi_in_t   in_data,
  input  ofvi_pkg::ofvi_cfg_t  cfg,
  input  wire                  in_push,
  input  wire                  q_full,
  output logic                 q_push,
  output ofvi_pkg::ofvi_work_t work
);
  import ofvi_pkg::*;

  logic [15:0] rf;
  logic [15:0] rr;

  assign rf     = in_data.range_valid ? in_data.range_filtered_mm : 16'd0;
  assign rr     = in_data.range_valid ? in_data.range_raw_mm : 16'd0;
  assign q_push = in_push && !q_full;

  always_comb begin
    work.flow_ok     = in_data.range_valid && (in_data.flow_quality != 8'd0);
    work.range_valid = in_data.range_valid;
    work.flow_mag[0] = abs16(in_data.flow_x_px);
    work.flow_mag[1] = abs16(in_data.flow_y_px);
    work.flow_neg[0] = in_data.flow_x_px[15];
    work.flow_neg[1] = in_data.flow_y_px[15];
    work.flow_pos[0] = !in_data.flow_x_px[15] && (in_data.flow_x_px != 16'sd0);
    work.flow_pos[1] = !in_data.flow_y_px[15] && (in_data.flow_y_px != 16'sd0);
    // body x from sensor y, body y from negated sensor x
    work.rate_mag[0] = abs16(in_data.sensor_rate_y);
    work.rate_neg[0] = in_data.sensor_rate_y[15];
    work.rate_mag[1] = abs16(in_data.sensor_rate_x);
    work.rate_neg[1] = !in_data.sensor_rate_x[15] && (in_data.sensor_rate_x != 16'sd0);
    work.rate_mag[2] = abs16(in_data.sensor_rate_z);
    work.rate_neg[2] = in_data.sensor_rate_z[15];
    work.range_f     = rf;
    work.ground      = cfg.use_filtered_range ? rf : rr;
    work.interval    = (in_data.frame_interval_us == 16'd0) ? 16'd1
                                                             : in_data.frame_interval_us;
    work.dt          = in_data.since_last_us;
    work.age         = in_data.range_age_us;
    work.qual        = in_data.flow_quality;
  end

endmodule

`default_nettype wire

// ===== hdl/ofvi_queue.sv =====
// ----------------------------------------------------------------------------
// ofvi_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofvi_queue #(
  parameter int DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  ofvi_pkg::ofvi_work_t wdata,
  output logic                 full,
  input  wire                  pop,
  output ofvi_pkg::ofvi_work_t rdata,
  output logic                 empty
);
  import ofvi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ofvi_work_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ofvi_back.sv =====
// ----------------------------------------------------------------------------
// ofvi_back
// sequencer for velocity, integration, low-pass and report of one frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ofvi_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ofvi_pkg::ofvi_cfg_t  cfg,
  input  wire                  q_empty,
  input  ofvi_pkg::ofvi_work_t q_data,
  output logic                 q_pop,
  input  wire                  out_pop,
  output logic                 out_empty,
  output ofvi_pkg::ofvi_out_t  out_data
);
  import ofvi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VMUL_A, ST_VMUL_B, ST_VMUL_C, ST_VKICK, ST_VDIV,
    ST_GMUL, ST_GKICK, ST_GDIV, ST_ACC, ST_LP_MUL, ST_LP_SUM,
    ST_MKICK, ST_MDIV, ST_OUT
  } state_t;

  state_t                  state_r;
  ofvi_work_t              item_r;
  logic [1:0]              axis_r;
  logic [39:0]             prod_a_r;
  logic [55:0]             prod_b_r;
  logic [DIV_NUM_W-1:0]    num_r;
  logic                    ovf_r;
  logic [1:0][31:0]        ang_inc_r;
  logic [1:0][15:0]        vel_r;
  logic [2:0][32:0]        gyro_inc_r;
  logic signed [33:0]      lp_p1_r [2];
  logic signed [33:0]      lp_p2_r [2];
  logic [1:0][31:0]        vsum_r;
  logic [15:0]             vf_r;
  logic [1:0][15:0]        lp_r;
  logic [31:0]             tsum_r;
  logic [1:0][31:0]        fsum_r;
  logic [2:0][31:0]        gsum_r;
  logic [23:0]             qsum_r;
  logic [7:0]              tc_r;
  logic [31:0]             age_r;
  logic [7:0]              tc_inc_r;
  logic                    report_r;
  logic [1:0][15:0]        mean_v_r;
  logic [7:0]              mq_r;
  logic                    out_valid_r;
  ofvi_out_t               out_r;

  ofvi_div_req_t div_req;
  ofvi_div_rsp_t div_rsp;
  logic [16:0]   w_c;
  logic [69:0]   vprod_c;
  logic [35:0]   gprod_c;
  logic [7:0]    limit_c;
  logic          out_free;
  logic          out_load;
  ofvi_out_t     out_c;

  ofvi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign w_c      = (cfg.new_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.new_weight;
  assign vprod_c  = 70'(prod_b_r) * 70'(SCALE_15625);
  assign gprod_c  = 36'(item_r.rate_mag[axis_r]) * 36'(item_r.dt);
  assign limit_c  = (cfg.throttle_factor == 8'd0) ? 8'd1 : cfg.throttle_factor;
  assign out_free = !out_valid_r || out_pop;
  assign out_load = (state_r == ST_OUT) && out_free;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    div_req.start = (state_r == ST_VKICK) || (state_r == ST_GKICK) || (state_r == ST_MKICK);
    div_req.num   = num_r;
    div_req.den   = '0;
    case (state_r)
      ST_VKICK: div_req.den = item_r.interval;
      ST_GKICK: div_req.den = SCALE_15625;
      ST_MKICK: begin
        div_req.den = vf_r;
        if (axis_r == 2'd2) div_req.num = DIV_NUM_W'(qsum_r);
        else div_req.num = DIV_NUM_W'(abs32(vsum_r[axis_r[0]]));
      end
      default: div_req.den = '0;
    endcase
  end

  always_comb begin
    out_c = '0;
    if (report_r) begin
      out_c.report_valid       = 1'b1;
      out_c.ground_distance_mm = item_r.ground;
      out_c.velocity_x         = cfg.use_lowpass ? lp_r[0] : mean_v_r[0];
      out_c.velocity_y         = cfg.use_lowpass ? lp_r[1] : mean_v_r[1];
      out_c.window_time_us     = tsum_r;
      out_c.window_flow_x      = fsum_r[0];
      out_c.window_flow_y      = fsum_r[1];
      out_c.window_gyro_x      = gsum_r[0];
      out_c.window_gyro_y      = gsum_r[1];
      out_c.window_gyro_z      = gsum_r[2];
      out_c.mean_quality       = mq_r;
      out_c.range_age_out_us   = age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vsum_r      <= '0;
      vf_r        <= '0;
      lp_r        <= '0;
      tsum_r      <= '0;
      fsum_r      <= '0;
      gsum_r      <= '0;
      qsum_r      <= '0;
      tc_r        <= '0;
      age_r       <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            item_r   <= q_data;
            vel_r    <= '0;
            mean_v_r <= '0;
            mq_r     <= '0;
            axis_r   <= 2'd0;
            state_r  <= q_data.flow_ok ? ST_VMUL_A : ST_ACC;
          end
        end
        ST_VMUL_A: begin
          prod_a_r <= 40'(item_r.flow_mag[axis_r[0]]) * 40'(cfg.inv_focal_length);
          state_r  <= ST_VMUL_B;
        end
        ST_VMUL_B: begin
          prod_b_r             <= 56'(prod_a_r) * 56'(item_r.range_f);
          ang_inc_r[axis_r[0]] <= prod_a_r[39:8];
          state_r              <= ST_VMUL_C;
        end
        ST_VMUL_C: begin
          num_r   <= DIV_NUM_W'(vprod_c[69:26]);
          ovf_r   <= prod_b_r[55:32] >= 24'(item_r.interval);
          state_r <= ST_VKICK;
        end
        ST_VKICK: state_r <= ST_VDIV;
        ST_VDIV: begin
          if (div_rsp.done) begin
            // positive pixel flow maps to negative velocity
            vel_r[axis_r[0]] <= mag_to_s16(div_rsp.quot, ovf_r, item_r.flow_pos[axis_r[0]]);
            if (axis_r == 2'd0) begin
              axis_r  <= 2'd1;
              state_r <= ST_VMUL_A;
            end else begin
              axis_r  <= 2'd0;
              state_r <= ST_GMUL;
            end
          end
        end
        ST_GMUL: begin
          // rate * dt * 64 / 15625 equals rate * dt * 4096 / 10^6
          num_r   <= {6'd0, gprod_c, 6'd0};
          state_r <= ST_GKICK;
        end
        ST_GKICK: state_r <= ST_GDIV;
        ST_GDIV: begin
          if (div_rsp.done) begin
            gyro_inc_r[axis_r] <= item_r.rate_neg[axis_r]
                                  ? 33'(-{5'd0, div_rsp.quot[27:0]})
                                  : {5'd0, div_rsp.quot[27:0]};
            if (axis_r == 2'd2) begin
              axis_r  <= 2'd0;
              state_r <= ST_ACC;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= ST_GMUL;
            end
          end
        end
        ST_ACC: begin
          if (item_r.range_valid) age_r <= item_r.age;
          if (item_r.flow_ok) begin
            logic [32:0] t;
            logic [24:0] q;
            logic [33:0] ax;
            logic [33:0] ay;
            for (int i = 0; i < 2; i++) begin
              vsum_r[i] <= sat32(34'($signed(vsum_r[i])) + 34'($signed(vel_r[i])));
            end
            if (vf_r != 16'hFFFF) vf_r <= vf_r + 16'd1;
            t = {1'b0, tsum_r} + 33'(item_r.dt);
            tsum_r <= t[32] ? 32'hFFFF_FFFF : t[31:0];
            ax = {2'b00, ang_inc_r[0]};
            ay = {2'b00, ang_inc_r[1]};
            fsum_r[0] <= sat32(34'($signed(fsum_r[0]))
                               + (item_r.flow_neg[1] ? 34'(-ay) : ay));
            fsum_r[1] <= sat32(34'($signed(fsum_r[1]))
                               + (item_r.flow_neg[0] ? ax : 34'(-ax)));
            for (int g = 0; g < 3; g++) begin
              gsum_r[g] <= sat32(34'($signed(gsum_r[g])) + 34'($signed(gyro_inc_r[g])));
            end
            q = {1'b0, qsum_r} + 25'(item_r.qual);
            qsum_r <= q[24] ? 24'hFF_FFFF : q[23:0];
          end
          state_r <= ST_LP_MUL;
        end
        ST_LP_MUL: begin
          for (int i = 0; i < 2; i++) begin
            lp_p1_r[i] <= $signed({1'b0, w_c}) * $signed(vel_r[i]);
            lp_p2_r[i] <= $signed({1'b0, 17'(WEIGHT_ONE - w_c)}) * $signed(lp_r[i]);
          end
          state_r <= ST_LP_SUM;
        end
        ST_LP_SUM: begin
          logic signed [35:0] s;
          logic [7:0]         tn;
          logic               rep;
          for (int i = 0; i < 2; i++) begin
            s = 36'(lp_p1_r[i]) + 36'(lp_p2_r[i]) + 36'sd32768;
            lp_r[i] <= sat16(s[35:16]);
          end
          tn  = tc_r + 8'd1;
          rep = (tn >= limit_c);
          tc_inc_r <= tn;
          report_r <= rep;
          if (rep && vf_r != 16'd0) begin
            axis_r  <= cfg.use_lowpass ? 2'd2 : 2'd0;
            state_r <= ST_MKICK;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_MKICK: state_r <= ST_MDIV;
        ST_MDIV: begin
          if (div_rsp.done) begin
            if (axis_r == 2'd2) begin
              mq_r    <= (div_rsp.quot > 48'd255) ? 8'hFF : div_rsp.quot[7:0];
              state_r <= ST_OUT;
            end else begin
              mean_v_r[axis_r[0]] <= mag_to_s16(div_rsp.quot, 1'b0,
                                                vsum_r[axis_r[0]][31]);
              axis_r  <= axis_r + 2'd1;
              state_r <= ST_MKICK;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_r       <= out_c;
            tc_r        <= report_r ? 8'd0 : tc_inc_r;
            if (report_r) begin
              vsum_r <= '0;
              vf_r   <= '0;
              tsum_r <= '0;
              fsum_r <= '0;
              gsum_r <= '0;
              qsum_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  `OFVI_NEVER(a_div_done_unexpected, clk, rst_n, div_rsp.done && !(state_r == ST_VDIV || state_r == ST_GDIV || state_r == ST_MDIV))
  `OFVI_ASSERT(a_report_clears_window, clk, rst_n, (state_r == ST_OUT && out_free && report_r) |=> (tc_r == 8'd0 && vf_r == 16'd0))
  `OFVI_ASSERT(a_quiet_beat_zero, clk, rst_n, (out_valid_r && !out_r.report_valid) |-> (out_r.window_time_us == 32'd0 && out_r.mean_quality == 8'd0))

endmodule

`default_nettype wire
